// ===== rtl/core/hsa_pkg.sv =====
// Shared types, codes and helpers for the handle slot allocator.
`timescale 1ns / 1ps

package hsa_pkg;

  localparam int WORD_W     = 64;
  localparam int BIT_W      = 6;
  localparam int CMD_W      = 2;
  localparam int HANDLE_W   = 12;
  localparam int STATUS_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE  = 2'd0,
    CMD_DESTROY = 2'd1,
    CMD_QUERY   = 2'd2,
    CMD_NONE    = 2'd3
  } command_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_BAD_HANDLE = 2'd1,
    ST_NOT_LIVE   = 2'd2,
    ST_NO_SPACE   = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic load;
    logic commit;
  } ctrl_cmd_t;

  function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ===== rtl/core/hsa_ctrl.sv =====
// Control state machine: input handshake, commit sequencing and result valid.
`timescale 1ns / 1ps

module hsa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output hsa_pkg::ctrl_cmd_t cmd
);
  import hsa_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid_r || !out_stall) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/hsa_datapath.sv =====
// Datapath: bitmap word memory, word summaries, allocate/free logic, result register.
`timescale 1ns / 1ps

module hsa_datapath #(
  parameter int SLOTS = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  hsa_pkg::ctrl_cmd_t                 cmd,
  input  logic [hsa_pkg::CMD_W-1:0]          in_command,
  input  logic [hsa_pkg::HANDLE_W-1:0]       in_handle,
  output logic [hsa_pkg::STATUS_W-1:0]       out_status,
  output logic [hsa_pkg::HANDLE_W-1:0]       out_new_handle,
  output logic                               out_is_live
);
  import hsa_pkg::*;

  localparam int WORDS     = (SLOTS + WORD_W - 1) / WORD_W;
  localparam int WIDX_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int LAST_BITS = SLOTS - (WORDS - 1) * WORD_W;
  localparam logic [WORD_W-1:0] PAD_LAST = ~((WORD_W'(1) << LAST_BITS) - WORD_W'(1));
  localparam logic [HANDLE_W:0] SLOTS_L = (HANDLE_W + 1)'(SLOTS);
  localparam logic [WIDX_W-1:0] LAST_W = WIDX_W'(WORDS - 1);

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORDS-1:0]  word_valid_r;
  logic [WORDS-1:0]  full_r;

  logic [CMD_W-1:0]    cmd_r;
  logic [BIT_W-1:0]    bit_r;
  logic                in_range_r;
  logic                found_r;
  logic [WIDX_W-1:0]   addr_r;
  logic [WORD_W-1:0]   rdata_r;
  logic                rvalid_r;

  logic [STATUS_W-1:0] status_r;
  logic [HANDLE_W-1:0] new_handle_r;
  logic                is_live_r;

  logic [HANDLE_W-1:0] hm1;
  logic                in_range;
  logic                found;
  logic [WIDX_W-1:0]   free_w;
  logic [WIDX_W-1:0]   addr;

  logic [WORD_W-1:0]   word;
  logic [WORD_W-1:0]   pad;
  logic [BIT_W-1:0]    pos;
  logic [WORD_W-1:0]   new_word;
  logic                wr_en;
  logic                new_full;
  status_t             status_nxt;
  logic [HANDLE_W-1:0] new_handle_nxt;
  logic                is_live_nxt;

  always_comb begin
    hm1      = in_handle - HANDLE_W'(1);
    in_range = (in_handle != '0) && ({1'b0, in_handle} <= SLOTS_L);
    found    = 1'b0;
    free_w   = '0;
    for (int w = WORDS - 1; w >= 0; w--) begin
      if (!full_r[w]) begin
        found  = 1'b1;
        free_w = WIDX_W'(w);
      end
    end
    if (command_t'(in_command) == CMD_CREATE) begin
      addr = free_w;
    end else if (in_range) begin
      addr = hm1[BIT_W +: WIDX_W];
    end else begin
      addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r      <= in_command;
      bit_r      <= hm1[BIT_W-1:0];
      in_range_r <= in_range;
      found_r    <= found;
      addr_r     <= addr;
      rdata_r    <= mem[addr];
      rvalid_r   <= word_valid_r[addr];
    end
  end

  always_comb begin
    word           = rvalid_r ? rdata_r : '0;
    pad            = (addr_r == LAST_W) ? PAD_LAST : '0;
    pos            = lowest_zero(word | pad);
    new_word       = word;
    wr_en          = 1'b0;
    status_nxt     = ST_OK;
    new_handle_nxt = '0;
    is_live_nxt    = 1'b0;
    case (command_t'(cmd_r))
      CMD_CREATE: begin
        if (found_r) begin
          new_word       = word | (WORD_W'(1) << pos);
          wr_en          = 1'b1;
          new_handle_nxt = HANDLE_W'({addr_r, pos}) + HANDLE_W'(1);
        end else begin
          status_nxt = ST_NO_SPACE;
        end
      end
      CMD_DESTROY: begin
        if (!in_range_r) begin
          status_nxt = ST_BAD_HANDLE;
        end else if (!word[bit_r]) begin
          status_nxt = ST_NOT_LIVE;
        end else begin
          new_word = word & ~(WORD_W'(1) << bit_r);
          wr_en    = 1'b1;
        end
      end
      CMD_QUERY: begin
        is_live_nxt = in_range_r && word[bit_r];
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
    new_full = &(new_word | pad);
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      mem[addr_r] <= new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_valid_r <= '0;
      full_r       <= '0;
    end else if (cmd.commit && wr_en) begin
      word_valid_r[addr_r] <= 1'b1;
      full_r[addr_r]       <= new_full;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r     <= status_nxt;
      new_handle_r <= new_handle_nxt;
      is_live_r    <= is_live_nxt;
    end
  end

  assign out_status     = status_r;
  assign out_new_handle = new_handle_r;
  assign out_is_live    = is_live_r;

endmodule

// ===== rtl/core/handle_slot_allocator_top.sv =====
// Handle slot allocator: one transaction in, one result out, registered at commit.
// A new transaction waits until the last commits, as a bitmap word is read then written back.
// A result waiting on out_stall holds the commit cycle of the next transaction.
// Reset: synchronous, active low; word valid and full summary bits clear, so every slot
// reads free at once with no clearing pass.
`timescale 1ns / 1ps

module handle_slot_allocator_top #(
  parameter int SLOTS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hsa_pkg::CMD_W-1:0]     in_command,
  input  logic [hsa_pkg::HANDLE_W-1:0]  in_handle,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hsa_pkg::STATUS_W-1:0]  out_status,
  output logic [hsa_pkg::HANDLE_W-1:0]  out_new_handle,
  output logic                          out_is_live
);
  import hsa_pkg::*;

  ctrl_cmd_t cmd;

  hsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  hsa_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_command     (in_command),
    .in_handle      (in_handle),
    .out_status     (out_status),
    .out_new_handle (out_new_handle),
    .out_is_live    (out_is_live)
  );

endmodule
